FILE: rtl/iee_pkg.sv
// shared types and constants for the infix expression evaluator
// character codes, item kinds, pending operator codes, queue entry layout, unit control
// no dependencies
`timescale 1ns / 1ps

package iee_pkg;

    // character codes of the operators
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_STAR  = 8'd42;
    localparam logic [7:0] CHAR_SLASH = 8'd47;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    // item kinds produced by the front end
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_DIGIT = 3'd0;
    localparam kind_t KIND_ADD   = 3'd1;
    localparam kind_t KIND_SUB   = 3'd2;
    localparam kind_t KIND_MUL   = 3'd3;
    localparam kind_t KIND_DIV   = 3'd4;

    // operator joining the number being read to the term
    typedef logic [1:0] op_t;
    localparam op_t OP_NONE = 2'd0;
    localparam op_t OP_MUL  = 2'd1;
    localparam op_t OP_DIV  = 2'd2;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        kind_t              kind;
        logic signed [8:0]  digit;   // byte minus the code of zero
        logic               last;
    } item_t;

    // control towards the multiply / divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } mdu_ctrl_t;

endpackage

FILE: rtl/infix_expression_evaluator.sv
// top level of the infix expression evaluator: front queue, back sequencer
// depends on iee_pkg, iee_front, iee_back (with iee_mdu)
//
// channel   dir   tdata               tuser   tlast
// s_*       in    [7:0] char_byte     -       end_of_expr
// m_*       out   [31:0] expr_value   -       -
//
// a digit is added in while fetching; an operator, or a digit with the end mark, goes on
// to fold and after; folding a pending * or / waits on the one-bit-per-cycle unit
// an operator with the end mark folds once more, through the unit after * or /
// reset clears the queue, the sequencer and its accumulators; no clearing pass
// a four-entry queue takes characters one per cycle and drops s_tready only when full
// the result register lets the next expression run while a result waits for m_tready
`timescale 1ns / 1ps

module infix_expression_evaluator #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] char_byte
    input  logic        s_tlast,     // end_of_expr
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata      // [31:0] expr_value
);
    import iee_pkg::*;

    logic  item_valid;
    item_t item;
    logic  item_pop;

    iee_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    iee_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: rtl/iee_front.sv
// front end: accepts character transactions, classifies them and queues them
// depends on iee_pkg
`timescale 1ns / 1ps

module iee_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,     // [7:0] char_byte
    input  logic           s_tlast,     // end_of_expr
    output logic           item_valid,
    output iee_pkg::item_t item,
    input  logic           item_pop
);
    import iee_pkg::*;

    item_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    item_t              new_item;
    logic               push;

    always_comb
    begin
        new_item.last  = s_tlast;
        new_item.digit = $signed({1'b0, s_tdata}) - $signed({1'b0, CHAR_ZERO});
        case (s_tdata)
            CHAR_PLUS:  new_item.kind = KIND_ADD;
            CHAR_MINUS: new_item.kind = KIND_SUB;
            CHAR_STAR:  new_item.kind = KIND_MUL;
            CHAR_SLASH: new_item.kind = KIND_DIV;
            default:    new_item.kind = KIND_DIGIT;
        endcase
    end

    assign s_tready   = (count_reg != (FIFO_AW + 1)'(FIFO_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != '0);
    assign item       = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(item_pop && item_valid))
            count_next = count_reg + 1'b1;
        else if (!push && item_pop && item_valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= new_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (item_pop && item_valid)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/iee_mdu.sv
// shared iterative unit: shift-add multiply and restoring signed divide
// one bit per cycle; depends on iee_pkg
`timescale 1ns / 1ps

module iee_mdu #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iee_pkg::mdu_ctrl_t     ctrl,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);
    import iee_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH);

    logic                   busy_reg;
    logic                   fin_reg;
    logic                   is_div_reg;
    logic                   neg_reg;
    logic                   zero_reg;
    logic [CW-1:0]          cnt_reg;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] opa_reg;
    logic [VALUE_WIDTH-1:0] opb_reg;

    logic [VALUE_WIDTH-1:0] mag_a;
    logic [VALUE_WIDTH-1:0] mag_b;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   qbit;

    assign mag_a = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
    assign mag_b = b[VALUE_WIDTH-1] ? (~b + 1'b1) : b;

    // remainder shifted by one with the next dividend bit
    assign trial = {acc_reg, opa_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, opb_reg};
    assign qbit  = (trial >= {1'b0, opb_reg});

    assign done = fin_reg;

    always_comb
    begin
        if (!is_div_reg)
            result = acc_reg;
        else if (zero_reg)
            result = '0;
        else if (neg_reg)
            result = ~opa_reg + 1'b1;
        else
            result = opa_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            is_div_reg <= ctrl.is_div;
            acc_reg    <= '0;
            neg_reg    <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
            zero_reg   <= (b == '0);
            if (ctrl.is_div)
            begin
                opa_reg <= mag_a;
                opb_reg <= mag_b;
            end
            else
            begin
                opa_reg <= a;
                opb_reg <= b;
            end
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                acc_reg <= qbit ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
                opa_reg <= {opa_reg[VALUE_WIDTH-2:0], qbit};
            end
            else
            begin
                if (opb_reg[0])
                    acc_reg <= acc_reg + opa_reg;
                opa_reg <= {opa_reg[VALUE_WIDTH-2:0], 1'b0};
                opb_reg <= {1'b0, opb_reg[VALUE_WIDTH-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(VALUE_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/iee_back.sv
// back end: sequencer that folds numbers into terms and terms into the sum
// owns the result register; depends on iee_pkg and iee_mdu
`timescale 1ns / 1ps

module iee_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  iee_pkg::item_t item,
    output logic           item_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata     // [31:0] expr_value
);
    import iee_pkg::*;

    localparam logic [1:0] ST_FETCH = 2'd0;
    localparam logic [1:0] ST_FOLD  = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_AFTER = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic                   closing_reg, closing_next;
    kind_t                  kind_reg, kind_next;
    logic                   last_reg, last_next;
    logic [VALUE_WIDTH-1:0] sum_reg, sum_next;
    logic [VALUE_WIDTH-1:0] term_reg, term_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    op_t                    pend_reg, pend_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_data_reg, out_data_next;

    mdu_ctrl_t              mdu_ctrl;
    logic                   mdu_done;
    logic [VALUE_WIDTH-1:0] mdu_result;
    logic                   out_load;
    logic [VALUE_WIDTH-1:0] digit_ext;
    logic [VALUE_WIDTH-1:0] closed_sum;
    logic signed [63:0]     sum_ext;

    iee_mdu #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mdu_ctrl),
        .a      (term_reg),
        .b      (acc_reg),
        .done   (mdu_done),
        .result (mdu_result)
    );

    assign digit_ext  = VALUE_WIDTH'(item.digit);
    assign closed_sum = neg_reg ? (sum_reg - term_reg) : (sum_reg + term_reg);
    assign sum_ext    = 64'(signed'(closed_sum));

    assign item_pop = (state_reg == ST_FETCH) && item_valid;
    assign out_load = (state_reg == ST_AFTER) && closing_reg && (!out_valid_reg || m_tready);

    assign mdu_ctrl.start  = (state_reg == ST_FOLD) && (pend_reg == OP_MUL || pend_reg == OP_DIV);
    assign mdu_ctrl.is_div = (pend_reg == OP_DIV);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        closing_next   = closing_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        term_next      = term_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_FETCH:
            begin
                if (item_valid)
                begin
                    kind_next    = item.kind;
                    last_next    = item.last;
                    closing_next = 1'b0;
                    if (item.kind == KIND_DIGIT)
                    begin
                        acc_next = (acc_reg << 3) + (acc_reg << 1) + digit_ext;
                        if (item.last)
                        begin
                            closing_next = 1'b1;
                            state_next   = ST_FOLD;
                        end
                    end
                    else
                    begin
                        state_next = ST_FOLD;
                    end
                end
            end
            ST_FOLD:
            begin
                if (mdu_ctrl.start)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    // no pending operator: the number starts the term
                    term_next  = acc_reg;
                    acc_next   = '0;
                    state_next = ST_AFTER;
                end
            end
            ST_WAIT:
            begin
                if (mdu_done)
                begin
                    term_next  = mdu_result;
                    acc_next   = '0;
                    state_next = ST_AFTER;
                end
            end
            ST_AFTER:
            begin
                if (closing_reg)
                begin
                    if (out_load)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = sum_ext[31:0];
                        sum_next       = '0;
                        term_next      = '0;
                        acc_next       = '0;
                        pend_next      = OP_NONE;
                        neg_next       = 1'b0;
                        closing_next   = 1'b0;
                        state_next     = ST_FETCH;
                    end
                end
                else
                begin
                    case (kind_reg)
                        KIND_ADD, KIND_SUB:
                        begin
                            sum_next  = closed_sum;
                            term_next = '0;
                            pend_next = OP_NONE;
                            neg_next  = (kind_reg == KIND_SUB);
                        end
                        KIND_MUL: pend_next = OP_MUL;
                        KIND_DIV: pend_next = OP_DIV;
                        default:  pend_next = pend_reg;
                    endcase
                    if (last_reg)
                    begin
                        closing_next = 1'b1;
                        state_next   = ST_FOLD;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default: state_next = ST_FETCH;
        endcase
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FETCH;
            closing_reg   <= 1'b0;
            sum_reg       <= '0;
            term_reg      <= '0;
            acc_reg       <= '0;
            pend_reg      <= OP_NONE;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            closing_reg   <= closing_next;
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // queue is read only while fetching
    a_pop_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> state_reg == ST_FETCH)
        else $error("queue popped outside fetch");

    // the unit is started only with a multiply or divide pending
    a_mdu_start: assert property (@(posedge clk) disable iff (!rst_n)
        mdu_ctrl.start |-> (pend_reg == OP_MUL || pend_reg == OP_DIV))
        else $error("multiply/divide started without pending operator");

    // the term holds while the unit is working
    a_term_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && !mdu_done) |=> $stable(term_reg))
        else $error("term changed while waiting on multiply/divide");

    // emitting a result clears the expression state
    a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (sum_reg == '0 && pend_reg == OP_NONE && !neg_reg && m_tvalid))
        else $error("state not cleared after result");

endmodule

FILE: test/tb_infix_expression_evaluator.sv
// self-checking bench for infix_expression_evaluator: directed table, then random expressions
// every expression result is predicted here or taken from the directed table, and compared as the block hands it out
// depends on iee_pkg and the evaluator rtl
`timescale 1ns / 1ps

module tb_infix_expression_evaluator;

    import iee_pkg::*;

    localparam int          CHAR_TARGET  = 1500;
    localparam int          DRAIN_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        known;   // value below is the result to expect
        logic [31:0] value;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 24;

    localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        '{CHAR_ZERO,  1'b1, 1'b1, 32'd0},
        '{CHAR_PLUS,  1'b1, 1'b1, 32'd0},
        '{CHAR_MINUS, 1'b1, 1'b1, 32'd0},
        '{CHAR_STAR,  1'b1, 1'b1, 32'd0},
        '{CHAR_SLASH, 1'b1, 1'b1, 32'd0},
        '{8'hFF,      1'b1, 1'b1, 32'd207},
        '{8'h00,      1'b1, 1'b1, 32'hFFFF_FFD0},
        // division by zero
        '{"7",        1'b0, 1'b0, 32'd0},
        '{CHAR_SLASH, 1'b0, 1'b0, 32'd0},
        '{CHAR_ZERO,  1'b1, 1'b1, 32'd0},
        // 65536 * 32768 gives the most negative value, "1%" reads as -1
        '{"6",        1'b0, 1'b0, 32'd0},
        '{"5",        1'b0, 1'b0, 32'd0},
        '{"5",        1'b0, 1'b0, 32'd0},
        '{"3",        1'b0, 1'b0, 32'd0},
        '{"6",        1'b0, 1'b0, 32'd0},
        '{CHAR_STAR,  1'b0, 1'b0, 32'd0},
        '{"3",        1'b0, 1'b0, 32'd0},
        '{"2",        1'b0, 1'b0, 32'd0},
        '{"7",        1'b0, 1'b0, 32'd0},
        '{"6",        1'b0, 1'b0, 32'd0},
        '{"8",        1'b0, 1'b0, 32'd0},
        '{CHAR_SLASH, 1'b0, 1'b0, 32'd0},
        '{"1",        1'b0, 1'b0, 32'd0},
        '{"%",        1'b1, 1'b1, 32'h8000_0000}
    };

    localparam logic [7:0] OPERATOR_CHARS [4] = '{CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // predictor state
    logic [31:0] sum_acc;
    logic [31:0] term_acc;
    logic [31:0] operand_acc;
    op_t         pending;
    logic        term_subtract;

    logic [31:0] expr_results [$];
    logic [7:0]  expr_chars [$];
    int          chars_sent   = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;

    wire quiet_stretch = (chars_sent >= 600) && (chars_sent < 900);

    infix_expression_evaluator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // signed quotient, truncated toward zero, zero divisor gives zero
    function automatic logic [31:0] quotient(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] q;
        mag_a = a[31] ? -a : a;
        mag_b = b[31] ? -b : b;
        if (mag_b == 32'd0)
            return 32'd0;
        q = mag_a / mag_b;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    task automatic clear_evaluator();
        sum_acc       = '0;
        term_acc      = '0;
        operand_acc   = '0;
        pending       = OP_NONE;
        term_subtract = 1'b0;
    endtask

    task automatic fold_operand();
        case (pending)
            OP_MUL:  term_acc = term_acc * operand_acc;
            OP_DIV:  term_acc = quotient(term_acc, operand_acc);
            default: term_acc = operand_acc;
        endcase
        operand_acc = '0;
    endtask

    task automatic close_term();
        fold_operand();
        sum_acc  = term_subtract ? sum_acc - term_acc : sum_acc + term_acc;
        term_acc = '0;
        pending  = OP_NONE;
    endtask

    task automatic evaluate_char(input logic [7:0] ch, input logic last,
                                 output logic done, output logic [31:0] value);
        if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
            close_term();
            term_subtract = (ch == CHAR_MINUS);
        end
        else if (ch == CHAR_STAR || ch == CHAR_SLASH) begin
            fold_operand();
            pending = (ch == CHAR_STAR) ? OP_MUL : OP_DIV;
        end
        else begin
            // any other byte is a digit worth byte minus the code of zero
            operand_acc = operand_acc * 32'd10 + ({24'd0, ch} - {24'd0, CHAR_ZERO});
        end
        done  = last;
        value = '0;
        if (last) begin
            close_term();
            value = sum_acc;
            clear_evaluator();
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input logic last,
                             input logic known, input logic [31:0] typed);
        logic        done;
        logic [31:0] value;
        if (!quiet_stretch && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        evaluate_char(ch, last, done, value);
        if (done)
            expr_results.push_back(known ? typed : value);
        chars_sent++;
    endtask

    task automatic push_decimal(input logic [31:0] v);
        logic [7:0] digits [$];
        do begin
            digits.push_front(CHAR_ZERO + 8'(v % 32'd10));
            v = v / 32'd10;
        end while (v != 32'd0);
        foreach (digits[i])
            expr_chars.push_back(digits[i]);
    endtask

    // mostly well-formed expressions; empty operands, stray bytes and trailing operators mixed in
    task automatic build_expression();
        int operands;
        int pick;
        expr_chars.delete();
        operands = $urandom_range(1, 4);
        for (int i = 0; i < operands; i++) begin
            if (i > 0)
                expr_chars.push_back(OPERATOR_CHARS[$urandom_range(0, 3)]);
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                // empty operand
            end
            else if (pick == 1) begin
                repeat ($urandom_range(1, 3))
                    expr_chars.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick == 2) begin
                case ($urandom_range(0, 4))
                    0:       push_decimal(32'h7FFF_FFFF);
                    1:       push_decimal(32'h8000_0000);
                    2:       push_decimal(32'hFFFF_FFFF);
                    3:       push_decimal(32'd1);
                    default: push_decimal(32'h0001_0000);
                endcase
            end
            else if (pick == 3)
                push_decimal($urandom);
            else if (pick < 12)
                push_decimal($urandom_range(0, 9));
            else
                push_decimal($urandom_range(0, 999));
        end
        if ($urandom_range(0, 7) == 0)
            expr_chars.push_back(OPERATOR_CHARS[$urandom_range(0, 3)]);
        if (expr_chars.size() == 0)
            expr_chars.push_back(8'($urandom_range(0, 255)));
    endtask

    // result side: check each transaction, then pick the next ready
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expr_results.size() == 0) begin
                    $error("expr_value: no result expected, got %0d", $signed(m_tdata));
                    mismatches++;
                end
                else begin
                    want = expr_results.pop_front();
                    if (m_tdata !== want) begin
                        $error("expr_value: expected %0d, got %0d",
                               $signed(want), $signed(m_tdata));
                        mismatches++;
                    end
                end
            end
            m_tready <= quiet_stretch || ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clear_evaluator();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_TABLE[i])
            send_char(DIRECTED_TABLE[i].ch, DIRECTED_TABLE[i].last,
                      DIRECTED_TABLE[i].known, DIRECTED_TABLE[i].value);

        while (chars_sent < CHAR_TARGET) begin
            build_expression();
            foreach (expr_chars[i])
                send_char(expr_chars[i], i == expr_chars.size() - 1, 1'b0, 32'd0);
        end
        s_tvalid <= 1'b0;

        while (expr_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/iee_pkg.sv
rtl/iee_front.sv
rtl/iee_mdu.sv
rtl/iee_back.sv
rtl/infix_expression_evaluator.sv
test/tb_infix_expression_evaluator.sv
